// ===== src/stq_pkg.sv =====
// Shared types, constants and codes for the sorted timer queue.
package stq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRIES_W   = 5;
	localparam int WIN_W       = 12;
	localparam int TIME_W      = 32;
	localparam int ID_W        = 8;

	localparam logic [WIN_W-1:0] LATE_WINDOW_RST = 12'd60;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_CHECK  = 2'd2;

	localparam logic [2:0] ST_ADDED   = 3'd0;
	localparam logic [2:0] ST_REMOVED = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_NOT_DUE = 3'd3;
	localparam logic [2:0] ST_FIRED   = 3'd4;
	localparam logic [2:0] ST_SKIPPED = 3'd5;
	localparam logic [2:0] ST_FULL    = 3'd6;

	typedef struct packed {
		logic [1:0]        command;
		logic [ID_W-1:0]   task_id;
		logic [TIME_W-1:0] exec_time;
		logic [TIME_W-1:0] now;
	} req_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [ID_W-1:0]      fired_id;
		logic [TIME_W-1:0]    fired_time;
		logic [ENTRIES_W-1:0] entries;
	} rsp_t;

	typedef struct packed {
		logic [TIME_W-1:0] due;
		logic [ID_W-1:0]   id;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} mem_wr_t;

endpackage

// ===== src/stq_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
module stq_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== src/stq_ctrl.sv =====
// Command sequencer: walks the entry memory for add, remove and check.
module stq_ctrl import stq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  req_t             req,
	input  logic [WIN_W-1:0] late_window,
	output logic             busy,
	output logic             done,
	output rsp_t             rsp,
	output mem_wr_t          mem_wr,
	output logic [IDX_W-1:0] mem_raddr,
	input  entry_t           mem_rdata
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_ADD  = 5'b00010,
		S_REM  = 5'b00100,
		S_CHK  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t           state_q;
	req_t             req_q;
	rsp_t             rsp_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic             iss_q;
	logic             v_s1;
	logic [IDX_W-1:0] addr_s1;
	logic             fin_we_q;
	logic [IDX_W-1:0] fin_addr_q;
	entry_t           fin_data_q;

	logic [IDX_W-1:0]  last_idx;
	logic              is_full;
	logic              later;
	logic              add_stop;
	logic              rem_keep;
	logic              rem_end;
	logic              chk_head;
	logic              not_due;
	logic              chk_end;
	logic [TIME_W-1:0] lag;
	logic              in_window;

	assign last_idx  = IDX_W'(cnt_q - 1'b1);
	assign is_full   = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign later     = (mem_rdata.due > req_q.exec_time);
	assign add_stop  = (state_q == S_ADD) && v_s1 && (!later || addr_s1 == '0);
	assign rem_keep  = (state_q == S_REM) && v_s1 && (mem_rdata.id != req_q.task_id);
	assign rem_end   = (state_q == S_REM) && v_s1 && (addr_s1 == last_idx);
	assign chk_head  = (state_q == S_CHK) && v_s1 && (addr_s1 == '0);
	assign not_due   = chk_head && (mem_rdata.due > req_q.now);
	assign chk_end   = (state_q == S_CHK) && v_s1 && (not_due || addr_s1 == last_idx);
	assign lag       = req_q.now - mem_rdata.due;
	assign in_window = (lag < TIME_W'(late_window));

	assign busy      = (state_q != S_IDLE);
	assign done      = (state_q == S_FIN);
	assign mem_raddr = rd_ptr_q;

	assign rsp = '{status: rsp_q.status, fired_id: rsp_q.fired_id,
		fired_time: rsp_q.fired_time, entries: ENTRIES_W'(cnt_q)};

	// Writes always land below (remove, check) or above (add) every read still
	// in flight, so no forwarding is needed.
	always_comb begin
		mem_wr = '{we: 1'b0, addr: '0, data: mem_rdata};
		case (state_q)
			S_ADD: begin
				if (v_s1 && later) begin
					mem_wr.we   = 1'b1;
					mem_wr.addr = IDX_W'(addr_s1 + 1'b1);
				end
			end
			S_REM: begin
				if (rem_keep) begin
					mem_wr.we   = 1'b1;
					mem_wr.addr = wr_ptr_q[IDX_W-1:0];
				end
			end
			S_CHK: begin
				if (v_s1 && addr_s1 != '0) begin
					mem_wr.we   = 1'b1;
					mem_wr.addr = IDX_W'(addr_s1 - 1'b1);
				end
			end
			S_FIN: begin
				mem_wr.we   = fin_we_q;
				mem_wr.addr = fin_addr_q;
				mem_wr.data = fin_data_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			iss_q    <= 1'b0;
			v_s1     <= 1'b0;
			fin_we_q <= 1'b0;
		end else begin
			v_s1 <= iss_q;
			case (state_q)
				S_IDLE: begin
					wr_ptr_q <= '0;
					if (start) begin
						case (req.command)
							CMD_ADD: begin
								if (is_full) begin
									state_q <= S_FIN;
								end else if (cnt_q == '0) begin
									state_q  <= S_FIN;
									cnt_q    <= CNT_W'(1);
									fin_we_q <= 1'b1;
								end else begin
									state_q  <= S_ADD;
									rd_ptr_q <= last_idx;
									iss_q    <= 1'b1;
								end
							end
							CMD_REMOVE: begin
								if (cnt_q == '0) begin
									state_q <= S_FIN;
								end else begin
									state_q  <= S_REM;
									rd_ptr_q <= '0;
									iss_q    <= 1'b1;
								end
							end
							default: begin
								if (cnt_q == '0) begin
									state_q <= S_FIN;
								end else begin
									state_q  <= S_CHK;
									rd_ptr_q <= '0;
									iss_q    <= 1'b1;
								end
							end
						endcase
					end
				end
				S_ADD: begin
					// walk down from the tail
					if (iss_q && !add_stop) begin
						if (rd_ptr_q == '0) begin
							iss_q <= 1'b0;
						end else begin
							rd_ptr_q <= rd_ptr_q - 1'b1;
						end
					end
					if (add_stop) begin
						state_q  <= S_FIN;
						iss_q    <= 1'b0;
						fin_we_q <= 1'b1;
						cnt_q    <= cnt_q + 1'b1;
					end
				end
				S_REM, S_CHK: begin
					if (iss_q && !chk_end) begin
						if (rd_ptr_q == last_idx) begin
							iss_q <= 1'b0;
						end else begin
							rd_ptr_q <= rd_ptr_q + 1'b1;
						end
					end
					if (rem_keep) begin
						wr_ptr_q <= wr_ptr_q + 1'b1;
					end
					if (rem_end) begin
						state_q <= S_FIN;
						iss_q   <= 1'b0;
						cnt_q   <= rem_keep ? CNT_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
					end
					if (chk_end) begin
						state_q <= S_FIN;
						iss_q   <= 1'b0;
						if (!not_due) begin
							cnt_q <= cnt_q - 1'b1;
						end
					end
				end
				S_FIN: begin
					state_q  <= S_IDLE;
					fin_we_q <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_ptr_q;
		if (state_q == S_IDLE && start) begin
			req_q            <= req;
			rsp_q.fired_id   <= '0;
			rsp_q.fired_time <= '0;
			rsp_q.entries    <= '0;
			fin_addr_q       <= '0;
			fin_data_q       <= '{due: req.exec_time, id: req.task_id};
			case (req.command)
				CMD_ADD:    rsp_q.status <= is_full ? ST_FULL : ST_ADDED;
				CMD_REMOVE: rsp_q.status <= ST_REMOVED;
				default:    rsp_q.status <= ST_EMPTY;
			endcase
		end
		if (add_stop) begin
			fin_addr_q <= later ? '0 : IDX_W'(addr_s1 + 1'b1);
		end
		if (chk_head) begin
			if (not_due) begin
				rsp_q.status <= ST_NOT_DUE;
			end else begin
				rsp_q.status     <= in_window ? ST_FIRED : ST_SKIPPED;
				rsp_q.fired_id   <= mem_rdata.id;
				rsp_q.fired_time <= mem_rdata.due;
			end
		end
	end

endmodule

// ===== src/sorted_timer_queue.sv =====
// Top level of the sorted timer queue: config register, sequencer and entry memory.
//
// Usage: drive req and pulse start while busy is low; the item is taken at that
// edge. Commands: add a task (kept sorted by due time, ties in arrival order),
// remove every task with an id, or check the head against now (pop it as fired
// or skipped when due). Exactly one result comes back per item: done is high
// for one cycle with rsp valid in that cycle; the receiver cannot stall it.
// A full queue add, an add to an empty queue and a remove or check on
// an empty queue raise done in the cycle after the accepting edge. Other commands
// walk the entry memory one entry per cycle, at most QUEUE_DEPTH entries,
// before done; the walk is set by the single read port of the memory.
// busy falls the cycle after done, and start is taken again from then.
// The late window register is written through cfg_valid/cfg_ready/cfg_data
// (ready is always high); write it only while the block is idle.
// Reset clears the entry count and busy and loads the late window with 60;
// the memory itself is not cleared, since only counted entries are read.
module sorted_timer_queue import stq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	output logic             done,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [WIN_W-1:0] cfg_data
);

	logic [WIN_W-1:0] late_window_q;
	mem_wr_t          mem_wr;
	logic [IDX_W-1:0] mem_raddr;
	entry_t           mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			late_window_q <= LATE_WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			late_window_q <= cfg_data;
		end
	end

	stq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req        (req),
		.late_window(late_window_q),
		.busy       (busy),
		.done       (done),
		.rsp        (rsp),
		.mem_wr     (mem_wr),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	stq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_wr.we),
		.waddr(mem_wr.addr),
		.wdata(mem_wr.data),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

// ===== src/stq_chk.sv =====
// Port-level assertions for the sorted timer queue, bound to the top level.
module stq_chk import stq_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input req_t             req,
	input logic             done,
	input rsp_t             rsp,
	input logic             cfg_valid,
	input logic             cfg_ready,
	input logic [WIN_W-1:0] cfg_data
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a busy period");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("block stayed busy after its result");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_FULL |-> rsp.entries == ENTRIES_W'(QUEUE_DEPTH))
		else $error("full status with a count below the depth");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_EMPTY |->
			rsp.entries == '0 && rsp.fired_id == '0 && rsp.fired_time == '0)
		else $error("empty status with nonzero fields");

endmodule

bind sorted_timer_queue stq_chk u_stq_chk (.*);
